### rtl/core/toff_pkg.sv
// shared types, codes and constants of the turn offset frame receiver
`default_nettype none

package toff_pkg;

   // frame geometry
   localparam int FRAME_LENGTH = 9;
   localparam int POS_W        = $clog2(FRAME_LENGTH);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam int TURNS_W     = 10;
   localparam int TICK_W      = 8;
   localparam logic [TURNS_W-1:0] MAX_TURNS_RESET = 10'd432;
   localparam logic [TICK_W-1:0]  TIMEOUT_RESET   = 8'd100;

   // result widths
   localparam int SHIFT_W    = 11;
   localparam int RSP_DATA_W = 24;

   // frame bytes
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_T   = 8'h54;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] ID_FIRST = 8'h35;
   localparam logic [7:0] ID_LAST  = 8'h38;

   // single precision: exponent at which the unit bit sits at bit 0 of the significand
   localparam logic [7:0] EXP_UNIT = 8'd150;
   localparam logic [7:0] EXP_MAX  = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_TURNS = 1'b0,
      CSR_TIMEOUT   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_START = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      EV_IDLE     = 3'd0,
      EV_STORED   = 3'd1,
      EV_ACCEPTED = 3'd2,
      EV_REJECTED = 3'd3,
      EV_TIMEOUT  = 3'd4,
      EV_STARTED  = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_BYTE  = 3'd1,
      CMD_FRAME = 3'd2,
      CMD_TICK  = 3'd3,
      CMD_START = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic        frame_ok;
      logic [1:0]  wheel;
      logic [31:0] bits;
   } queue_entry_type;

endpackage

`default_nettype wire

### rtl/core/toff_front.sv
// front part: frame assembly and classification of incoming items
`default_nettype none

module toff_front
   import toff_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [1:0]      req_tuser,
   input  wire logic [7:0]      req_tdata,
   input  wire logic            queue_full,
   output logic                 push,
   output queue_entry_type      push_entry
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       frame_ff [FRAME_LENGTH];
   logic [7:0]       frame_in [FRAME_LENGTH];
   logic             last_byte;
   logic [7:0]       id_byte;
   logic [7:0]       wheel_byte;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;
   assign last_byte  = (pos_ff == POS_W'(FRAME_LENGTH - 1));

   always_comb begin
      for (int i = 0; i < FRAME_LENGTH; i++) begin
         frame_in[i] = frame_ff[i];
         if (POS_W'(i) == pos_ff) begin
            frame_in[i] = req_tdata;
         end
      end
   end

   assign id_byte    = frame_in[2];
   assign wheel_byte = id_byte - ID_FIRST;

   always_comb begin
      pos_in              = pos_ff;
      push_entry.cmd      = CMD_NONE;
      push_entry.frame_ok = (frame_in[0] == CHAR_A) && (frame_in[1] == CHAR_T)
                            && (frame_in[7] == CHAR_CR) && (frame_in[8] == CHAR_LF)
                            && (id_byte >= ID_FIRST) && (id_byte <= ID_LAST);
      push_entry.wheel    = wheel_byte[1:0];
      push_entry.bits     = {frame_in[6], frame_in[5], frame_in[4], frame_in[3]};
      case (req_tuser)
         KIND_BYTE: begin
            if (last_byte) begin
               push_entry.cmd = CMD_FRAME;
               pos_in         = '0;
            end else begin
               push_entry.cmd = CMD_BYTE;
               pos_in         = pos_ff + POS_W'(1);
            end
         end
         KIND_TICK: begin
            push_entry.cmd = CMD_TICK;
         end
         KIND_START: begin
            push_entry.cmd = CMD_START;
            pos_in         = '0;
         end
         default: begin
            push_entry.cmd = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (push) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && req_tuser == KIND_BYTE) begin
         frame_ff <= frame_in;
      end
   end

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_LENGTH - 1))
      else $error("frame position beyond frame length");

   a_frame_resets_pos: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.cmd == CMD_FRAME |=> pos_ff == '0)
      else $error("position not cleared after a complete frame");

endmodule

`default_nettype wire

### rtl/core/toff_queue.sv
// short queue of classified items between front and back
`default_nettype none

module toff_queue
   import toff_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire queue_entry_type  push_entry,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output queue_entry_type       head_entry
);

   queue_entry_type   entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

### rtl/core/toff_back.sv
// back part: float check and rounding, wheel status, timeout and result register
`default_nettype none

module toff_back
   import toff_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [TURNS_W-1:0]    max_turns,
   input  wire logic [TICK_W-1:0]     timeout_limit,
   input  wire logic                  head_valid,
   input  wire queue_entry_type       head_entry,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2:0]                 rsp_tuser,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic [3:0]         arrived_ff, arrived_in;
   logic [TICK_W-1:0]  tick_ff, tick_in, tick_sum;
   logic               rsp_valid_ff;
   event_type          rsp_event_ff, rsp_event_in;
   logic [1:0]         rsp_wheel_ff, rsp_wheel_in;
   logic [SHIFT_W-1:0] rsp_shift_ff, rsp_shift_in;
   logic [3:0]         rsp_mask_ff;

   // float decode
   logic [7:0]  expo, expo_eff, shift_full;
   logic [23:0] sig, floor_val, turns_wide;
   logic [4:0]  shift_amt;
   logic [54:0] shifted;
   logic [30:0] frac;
   logic        half, exp_big, over, dec_ok;
   logic [SHIFT_W-1:0] mag, val;

   assign expo       = head_entry.bits[30:23];
   assign expo_eff   = (expo == '0) ? 8'd1 : expo;
   assign sig        = {expo != '0, head_entry.bits[22:0]};
   assign exp_big    = (expo >= EXP_UNIT);
   assign shift_full = EXP_UNIT - expo_eff;
   assign shift_amt  = (shift_full > 8'd31) ? 5'd31 : shift_full[4:0];
   assign shifted    = {sig, 31'b0} >> shift_amt;
   assign floor_val  = shifted[54:31];
   assign frac       = shifted[30:0];
   assign half       = shifted[30];
   assign turns_wide = {14'b0, max_turns};
   // exact compare of the float magnitude against the limit
   assign over       = (floor_val > turns_wide) || ((floor_val == turns_wide) && (frac != '0));
   assign dec_ok     = !exp_big && !over;
   assign mag        = {1'b0, floor_val[9:0]} + {10'b0, half};
   assign val        = head_entry.bits[31] ? (~mag + SHIFT_W'(1)) : mag;

   assign pop      = head_valid && (!rsp_valid_ff || rsp_tready);
   assign tick_sum = tick_ff + TICK_W'(1);

   always_comb begin
      arrived_in   = arrived_ff;
      tick_in      = tick_ff;
      rsp_event_in = EV_IDLE;
      rsp_wheel_in = '0;
      rsp_shift_in = '0;
      case (head_entry.cmd)
         CMD_BYTE: begin
            rsp_event_in = EV_STORED;
         end
         CMD_FRAME: begin
            if (head_entry.frame_ok && dec_ok) begin
               arrived_in   = arrived_ff | (4'b0001 << head_entry.wheel);
               rsp_event_in = EV_ACCEPTED;
               rsp_wheel_in = head_entry.wheel;
               rsp_shift_in = val;
            end else begin
               rsp_event_in = EV_REJECTED;
            end
         end
         CMD_TICK: begin
            if (arrived_ff != 4'hF) begin
               if (tick_sum >= timeout_limit) begin
                  tick_in      = '0;
                  rsp_event_in = EV_TIMEOUT;
               end else begin
                  tick_in = tick_sum;
               end
            end
         end
         CMD_START: begin
            tick_in      = '0;
            rsp_event_in = EV_STARTED;
         end
         default: begin
            rsp_event_in = EV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arrived_ff   <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            arrived_ff   <= arrived_in;
            tick_ff      <= tick_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_event_ff <= rsp_event_in;
         rsp_wheel_ff <= rsp_wheel_in;
         rsp_shift_ff <= rsp_shift_in;
         rsp_mask_ff  <= arrived_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tdata  = {6'b0, (rsp_mask_ff == 4'hF), rsp_mask_ff, rsp_shift_ff, rsp_wheel_ff};

   a_accept_sets_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff == EV_ACCEPTED |-> rsp_mask_ff[rsp_wheel_ff])
      else $error("accepted frame without its wheel bit");

   a_timeout_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      pop && rsp_event_in == EV_TIMEOUT |=> tick_ff == '0 && arrived_ff != 4'hF)
      else $error("timeout left tick count running");

   a_mask_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_mask_ff == arrived_ff)
      else $error("reported mask differs from wheel status");

endmodule

`default_nettype wire

### rtl/core/turn_offset_frame_receiver_unit.sv
// top level of the turn offset frame receiver: configuration registers and part wiring
// an accepted transaction is written into the queue, then into the result register that drives rsp_
// throughput: one transaction per cycle; req_tready falls only when the two-entry queue is full
// reset (synchronous, active high) clears frame position, wheel bits, tick count and queue
// reset loads max_turns with 432 and timeout_limit with 100
`default_nettype none

module turn_offset_frame_receiver_unit
   import toff_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [1:0]             req_tuser,   // [1:0] kind
   input  wire logic [7:0]             req_tdata,   // [7:0] byte_value
   // response channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [2:0]                  rsp_tuser,   // [2:0] event_res
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // [1:0] wheel, [12:2] shift_value,
                                                    // [16:13] received_mask, [17] all_received
   // configuration write channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers, written one transaction per cycle
   logic [TURNS_W-1:0] max_turns_ff;
   logic [TICK_W-1:0]  timeout_limit_ff;

   // front to queue
   logic            push;
   queue_entry_type push_entry;
   logic            queue_full;

   // queue to back
   logic            pop;
   logic            head_valid;
   queue_entry_type head_entry;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_turns_ff     <= MAX_TURNS_RESET;
         timeout_limit_ff <= TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_TURNS: max_turns_ff     <= csr_data[TURNS_W-1:0];
            CSR_TIMEOUT:   timeout_limit_ff <= csr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: keeps the frame bytes and position, checks header, id and trailer
   toff_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // queue lets the front keep taking items while a result waits on rsp_
   toff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: float range check and rounding, wheel bits, poll timeout, result register
   toff_back u_back (
      .clock         (clock),
      .reset         (reset),
      .max_turns     (max_turns_ff),
      .timeout_limit (timeout_limit_ff),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

`default_nettype wire
